/* sv/vnfbm_pkg.sv */
`timescale 1ns / 1ps
package vnfbm_pkg;

   localparam int GRID_RES_DEF = 64;
   localparam int MAX_OCT_DEF  = 8;

   // field widths
   localparam int PW  = 30;   // sample position, Q.16, below 2^30 for any grid
   localparam int AW  = 32;   // amplitude, Q20.12, saturated
   localparam int FQW = 48;   // frequency, Q36.12, saturated
   localparam int TW  = 52;   // weighted noise sum, room for 16 octaves
   localparam int SW  = 37;   // amplitude sum, room for 16 octaves
   localparam int NW  = 5;    // octave count after clamping
   localparam int DW  = 16;   // density

   localparam logic [31:0] HASH_X   = 32'd1087;
   localparam logic [31:0] HASH_Y   = 32'd2311;
   localparam logic [31:0] HASH_Z   = 32'd4513;
   localparam logic [31:0] HASH_OFS = 32'd12345;
   localparam logic [31:0] HASH_MUL = 32'h045d9f3b;

   localparam logic [AW-1:0]  AMP_INIT  = AW'(2048);
   localparam logic [AW-1:0]  AMP_ONE   = AW'(1);
   localparam logic [FQW-1:0] FREQ_INIT = FQW'(4096);

   typedef enum logic [2:0] {
      CSR_MODE  = 3'd0,
      CSR_SCALE = 3'd1,
      CSR_OCT   = 3'd2,
      CSR_LAC   = 3'd3,
      CSR_GAIN  = 3'd4
   } csr_index_type;

   localparam logic        MODE_RST  = 1'b1;
   localparam logic [23:0] SCALE_RST = 24'd65536;
   localparam logic [3:0]  OCT_RST   = 4'd4;
   localparam logic [15:0] LAC_RST   = 16'd8192;
   localparam logic [15:0] GAIN_RST  = 16'd2048;

   typedef struct packed {
      logic [2:0][PW-1:0] pos;
      logic [AW-1:0]      amp;
      logic [FQW-1:0]     freq;
      logic [TW-1:0]      total;
      logic [SW-1:0]      sum;
      logic [NW-1:0]      oct_n;
      logic               mode;
   } oct_bus_type;

endpackage

/* sv/vnfbm_octave_cell.sv */
`timescale 1ns / 1ps
module vnfbm_octave_cell #(
   parameter int OCT_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  vnfbm_pkg::oct_bus_type in_bus,
   input  logic [15:0]            octave_gain,
   input  logic [15:0]            lacunarity,
   output logic                   out_vld,
   output vnfbm_pkg::oct_bus_type out_bus
);

   localparam int NST = 10;
   localparam int PW  = vnfbm_pkg::PW;
   localparam int AW  = vnfbm_pkg::AW;
   localparam int FQW = vnfbm_pkg::FQW;
   localparam int TW  = vnfbm_pkg::TW;
   localparam int SW  = vnfbm_pkg::SW;
   localparam int NW  = vnfbm_pkg::NW;

   function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] t);
      logic [32:0] acc;
      acc = 33'(a) * 33'(17'h10000 - 17'(t)) + 33'(b) * 33'(t);
      return acc[31:16];
   endfunction

   vnfbm_pkg::oct_bus_type bus_ff [NST];
   logic [NST-1:0] vld_ff;

   logic [2:0][PW+23:0] pfl_ff, pfh_ff;
   logic [39:0]         frl_ff, frh_ff;
   logic [2:0][31:0]    cidx_ff;
   logic [2:0][15:0]    frac_ff;
   logic [2:0][31:0]    a0_ff;
   logic [2:0][15:0]    f3_ff;
   logic [2:0][31:0]    sq_ff;
   logic [31:0]         base_ff;
   logic [2:0][15:0]    s4_ff, s5_ff, s6_ff, s7_ff, s8_ff;
   logic [7:0][31:0]    m1_ff, m2_ff;
   logic [3:0][15:0]    bx_ff;
   logic [1:0][15:0]    by_ff;
   logic [15:0]         nz_ff;

   logic [2:0][63:0]    qv;
   logic [63:0]         frv;
   logic [FQW-1:0]      freq_nx;
   logic [2:0][33:0]    sprod;
   logic [31:0]         base_in;
   logic [7:0][31:0]    hv, gv, m1_in, g2v, m2_in;
   logic [7:0][15:0]    lat;
   logic [3:0][15:0]    bx_in;
   logic [1:0][15:0]    by_in;
   logic [47:0]         amp_prod;
   logic [AW-1:0]       amp_nx;
   logic                act;
   vnfbm_pkg::oct_bus_type bus1_in, bus9_in;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         qv[a] = 64'(pfl_ff[a]) + (64'(pfh_ff[a]) << 24);
         sprod[a] = 34'(sq_ff[a][31:16]) * 34'(18'd196608 - {1'b0, f3_ff[a], 1'b0});
      end
      frv = 64'(frl_ff) + (64'(frh_ff) << 24);
      // frequency saturates at the top of its 48 bits
      freq_nx = (frv[63:60] != 4'd0) ? {FQW{1'b1}} : frv[59:12];
      bus1_in = bus_ff[0];
      bus1_in.freq = freq_nx;
      base_in = a0_ff[0] + a0_ff[1] + a0_ff[2] + vnfbm_pkg::HASH_OFS;
      for (int c = 0; c < 8; c++) begin
         hv[c] = base_ff + (c[0] ? vnfbm_pkg::HASH_X : 32'd0)
                         + (c[1] ? vnfbm_pkg::HASH_Y : 32'd0)
                         + (c[2] ? vnfbm_pkg::HASH_Z : 32'd0);
         gv[c] = hv[c] ^ (hv[c] >> 16);
         m1_in[c] = gv[c] * vnfbm_pkg::HASH_MUL;
         g2v[c] = m1_ff[c] ^ (m1_ff[c] >> 16);
         m2_in[c] = g2v[c] * vnfbm_pkg::HASH_MUL;
         lat[c] = m2_ff[c][15:0] ^ m2_ff[c][31:16];
      end
      for (int i = 0; i < 4; i++) begin
         bx_in[i] = blend(lat[2*i], lat[2*i+1], s6_ff[0]);
      end
      for (int i = 0; i < 2; i++) begin
         by_in[i] = blend(bx_ff[2*i], bx_ff[2*i+1], s7_ff[1]);
      end
      // octave 0 carries plain noise with unit weight, others only count in fractal mode
      act = (OCT_IDX == 0 && !bus_ff[8].mode) ||
            (bus_ff[8].mode && (NW'(OCT_IDX) < bus_ff[8].oct_n));
      amp_prod = 48'(bus_ff[8].amp) * 48'(octave_gain);
      amp_nx = (amp_prod[47:44] != 4'd0) ? {AW{1'b1}} : amp_prod[43:12];
      bus9_in = bus_ff[8];
      bus9_in.amp = amp_nx;
      if (act) begin
         bus9_in.total = bus_ff[8].total + TW'(48'(bus_ff[8].amp) * 48'(nz_ff));
         bus9_in.sum   = bus_ff[8].sum + SW'(bus_ff[8].amp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bus_ff[0] <= in_bus;
         for (int k = 1; k < NST; k++) begin
            if (k == 1) begin
               bus_ff[k] <= bus1_in;
            end else if (k == NST - 1) begin
               bus_ff[k] <= bus9_in;
            end else begin
               bus_ff[k] <= bus_ff[k-1];
            end
         end
         for (int a = 0; a < 3; a++) begin
            pfl_ff[a]  <= (PW+24)'(in_bus.pos[a]) * (PW+24)'(in_bus.freq[23:0]);
            pfh_ff[a]  <= (PW+24)'(in_bus.pos[a]) * (PW+24)'(in_bus.freq[47:24]);
            cidx_ff[a] <= qv[a][59:28];
            frac_ff[a] <= qv[a][27:12];
            f3_ff[a]   <= frac_ff[a];
            sq_ff[a]   <= 32'(frac_ff[a]) * 32'(frac_ff[a]);
            s4_ff[a]   <= sprod[a][31:16];
         end
         frl_ff   <= 40'(in_bus.freq[23:0]) * 40'(lacunarity);
         frh_ff   <= 40'(in_bus.freq[47:24]) * 40'(lacunarity);
         a0_ff[0] <= cidx_ff[0] * vnfbm_pkg::HASH_X;
         a0_ff[1] <= cidx_ff[1] * vnfbm_pkg::HASH_Y;
         a0_ff[2] <= cidx_ff[2] * vnfbm_pkg::HASH_Z;
         base_ff  <= base_in;
         s5_ff    <= s4_ff;
         s6_ff    <= s5_ff;
         s7_ff    <= s6_ff;
         s8_ff    <= s7_ff;
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         nz_ff    <= blend(by_ff[0], by_ff[1], s8_ff[2]);
      end
   end

   assign out_vld = vld_ff[NST-1];
   assign out_bus = bus_ff[NST-1];

endmodule

/* sv/vnfbm_divider.sv */
`timescale 1ns / 1ps
module vnfbm_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic [vnfbm_pkg::TW-1:0]  total,
   input  logic [vnfbm_pkg::SW-1:0]  sum,
   output logic                      out_vld,
   output logic [vnfbm_pkg::DW-1:0]  quo
);

   localparam int TW = vnfbm_pkg::TW;
   localparam int SW = vnfbm_pkg::SW;
   localparam int DW = vnfbm_pkg::DW;

   // one quotient bit per cell, most significant first; the quotient is a
   // weighted mean of 16-bit values so it never needs more than DW bits
   logic [DW-1:0]          vld_ff;
   logic [TW-1:0]          rem_ff [DW];
   logic [SW-1:0]          dsr_ff [DW];
   logic [DW-1:0]          quo_ff [DW];
   logic [DW-1:0]          zero_ff;

   logic [TW-1:0]          rem_src [DW];
   logic [SW-1:0]          dsr_src [DW];
   logic [DW-1:0]          quo_src [DW];
   logic [TW-1:0]          trial   [DW];
   logic [TW-1:0]          rem_in  [DW];
   logic [DW-1:0]          quo_in  [DW];

   always_comb begin
      for (int j = 0; j < DW; j++) begin
         rem_src[j] = (j == 0) ? total : rem_ff[(j == 0) ? 0 : j-1];
         dsr_src[j] = (j == 0) ? sum : dsr_ff[(j == 0) ? 0 : j-1];
         quo_src[j] = (j == 0) ? '0 : quo_ff[(j == 0) ? 0 : j-1];
         trial[j] = TW'(dsr_src[j]) << (DW - 1 - j);
         rem_in[j] = rem_src[j];
         quo_in[j] = quo_src[j];
         if (trial[j] <= rem_src[j]) begin
            rem_in[j] = rem_src[j] - trial[j];
            quo_in[j][DW-1-j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DW-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= {zero_ff[DW-2:0], (sum == '0)};
         for (int j = 0; j < DW; j++) begin
            rem_ff[j] <= rem_in[j];
            dsr_ff[j] <= dsr_src[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign out_vld = vld_ff[DW-1];
   assign quo     = zero_ff[DW-1] ? '0 : quo_ff[DW-1];

endmodule

/* sv/value_noise_fbm_3d_generator_top.sv */
// path: an accepted item passes the f1 and f2 registers, each octave cell, the
//   divider and the output register; throughput: one item per cycle unless
//   the output register is full and not taken; each octave cell is a ten-stage
//   pipeline and the divider takes one quotient bit per stage, so nothing is
//   iterated; reset clears all valid bits and loads the register reset values
`timescale 1ns / 1ps
module value_noise_fbm_3d_generator_top #(
   parameter int GRID_RES    = vnfbm_pkg::GRID_RES_DEF,
   parameter int MAX_OCTAVES = vnfbm_pkg::MAX_OCT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_voxel_x,
   input  logic [5:0]  req_voxel_y,
   input  logic [5:0]  req_voxel_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_density,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int PW = vnfbm_pkg::PW;
   localparam int NW = vnfbm_pkg::NW;
   // position divide by GRID_RES through an exact reciprocal
   localparam int          DIV_SH = PW + $clog2(GRID_RES);
   localparam logic [63:0] RECIP  =
      ((64'd1 << DIV_SH) + 64'(GRID_RES) - 64'd1) / 64'(GRID_RES);

   logic        mode_ff;
   logic [23:0] scale_ff;
   logic [3:0]  oct_ff;
   logic [15:0] lac_ff;
   logic [15:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= vnfbm_pkg::MODE_RST;
         scale_ff <= vnfbm_pkg::SCALE_RST;
         oct_ff   <= vnfbm_pkg::OCT_RST;
         lac_ff   <= vnfbm_pkg::LAC_RST;
         gain_ff  <= vnfbm_pkg::GAIN_RST;
      end else if (csr_write_en) begin
         case (vnfbm_pkg::csr_index_type'(csr_index))
            vnfbm_pkg::CSR_MODE:  mode_ff  <= csr_wdata[0];
            vnfbm_pkg::CSR_SCALE: scale_ff <= csr_wdata;
            vnfbm_pkg::CSR_OCT:   oct_ff   <= csr_wdata[3:0];
            vnfbm_pkg::CSR_LAC:   lac_ff   <= csr_wdata[15:0];
            vnfbm_pkg::CSR_GAIN:  gain_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] density_ff;

   // the whole pipe moves unless the output register is full and not taken
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   logic [2:0][5:0]    vox;
   logic [2:0][30:0]   mprod;
   logic [2:0][PW-1:0] m_ff;
   logic               f1_vld_ff, f1_mode_ff;
   logic [NW-1:0]      f1_n_ff, n_clamp;
   logic [2:0][63:0]   pprod;
   logic               f2_vld_ff;
   vnfbm_pkg::oct_bus_type f2_bus_ff, f2_bus_in;

   always_comb begin
      vox[0] = req_voxel_x;
      vox[1] = req_voxel_y;
      vox[2] = req_voxel_z;
      for (int a = 0; a < 3; a++) begin
         mprod[a] = 31'({vox[a], 1'b1}) * 31'(scale_ff);
         pprod[a] = 64'(m_ff[a]) * RECIP;
      end
      n_clamp = (32'(oct_ff) > MAX_OCTAVES) ? NW'(MAX_OCTAVES) : NW'(oct_ff);
      f2_bus_in.mode  = f1_mode_ff;
      f2_bus_in.oct_n = f1_n_ff;
      f2_bus_in.amp   = f1_mode_ff ? vnfbm_pkg::AMP_INIT : vnfbm_pkg::AMP_ONE;
      f2_bus_in.freq  = vnfbm_pkg::FREQ_INIT;
      f2_bus_in.total = '0;
      f2_bus_in.sum   = '0;
      for (int a = 0; a < 3; a++) begin
         f2_bus_in.pos[a] = PW'(pprod[a] >> DIV_SH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else if (en) begin
         f1_vld_ff <= req_valid;
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            m_ff[a] <= mprod[a][30:1];
         end
         f1_mode_ff <= mode_ff;
         f1_n_ff    <= n_clamp;
         f2_bus_ff  <= f2_bus_in;
      end
   end

   vnfbm_pkg::oct_bus_type chain_bus [MAX_OCTAVES+1];
   logic [MAX_OCTAVES:0]   chain_vld;

   assign chain_bus[0] = f2_bus_ff;
   assign chain_vld[0] = f2_vld_ff;

   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
      vnfbm_octave_cell #(
         .OCT_IDX(o)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .en          (en),
         .in_vld      (chain_vld[o]),
         .in_bus      (chain_bus[o]),
         .octave_gain (gain_ff),
         .lacunarity  (lac_ff),
         .out_vld     (chain_vld[o+1]),
         .out_bus     (chain_bus[o+1])
      );
   end

   logic        div_vld;
   logic [15:0] div_quo;

   vnfbm_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (chain_vld[MAX_OCTAVES]),
      .total   (chain_bus[MAX_OCTAVES].total),
      .sum     (chain_bus[MAX_OCTAVES].sum),
      .out_vld (div_vld),
      .quo     (div_quo)
   );

   assign rsp_valid_in = en ? div_vld : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         density_ff <= div_quo;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_density = density_ff;

endmodule

/* sv/vnfbm_checker.sv */
`timescale 1ns / 1ps
module vnfbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_density
);

   // a waiting item holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_density))
      else $error("result item changed while stalled");

   // input side only stalls when the output register is blocked
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_ready_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output blocked");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind value_noise_fbm_3d_generator_top vnfbm_checker u_vnfbm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_density (rsp_density)
);
